/* hdl/serial_line_editor_with_echo_defines.svh */
// Assertion macros used by the RTL of the serial line editor.
`ifndef SERIAL_LINE_EDITOR_WITH_ECHO_DEFINES_SVH
`define SERIAL_LINE_EDITOR_WITH_ECHO_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sle_pkg.sv */
package sle_pkg;

  localparam int LineDepthDef = 32;

  localparam int ByteW  = 8;
  localparam int StoreW = 7;
  localparam int CountW = 6;
  localparam int KindW  = 2;
  localparam int DataW  = 16;

  localparam logic [CountW-1:0] LimitRst = 6'd32;

  localparam logic [KindW-1:0] KindEcho = 2'd0;
  localparam logic [KindW-1:0] KindChar = 2'd1;
  localparam logic [KindW-1:0] KindEnd  = 2'd2;

  localparam logic [ByteW-1:0] ByteBs    = 8'h08;
  localparam logic [ByteW-1:0] ByteCr    = 8'h0D;
  localparam logic [ByteW-1:0] ByteSpace = 8'h20;
  localparam logic [ByteW-1:0] ByteTilde = 8'h7E;

endpackage

/* hdl/sle_ram.sv */
module sle_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/serial_line_editor_with_echo.sv */
// Serial line editor with echo.
// Input: one received byte per beat on s_axis (tdata[7:0]). Output: result
// beats on m_axis; tuser carries the kind (echo, line character, line end),
// tdata carries the byte and, on line end, the line length; tlast marks the
// final beat caused by one input byte. line_limit is written through
// cfg_we_i/cfg_wdata_i; the user must do so only while the block is idle,
// which the block itself does not enforce.
// An accepted printable byte moves to the echo state, which loads it into
// the output register; a backspace gives three echo beats. A carriage return
// walks the line memory: for each stored character a fetch state issues the
// registered read and a send state loads the output register; the line-end
// beat follows. Dropped and ignored bytes leave the block idle.
// The output register lets a new byte be taken while the last beat of the
// previous one still waits. When the receiver stalls, the block holds its
// state and stops taking bytes once its next beat needs the register.
// Reset empties the line and sets the limit to 32; the line memory itself
// is not cleared, since only written entries are ever read.
module serial_line_editor_with_echo #(
  parameter int LineDepth = sle_pkg::LineDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [sle_pkg::ByteW-1:0] s_axis_tdata_i,  // [7:0] rx_byte
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [sle_pkg::DataW-1:0] m_axis_tdata_o,  // [7:0] out_byte, [13:8] line_length
  output logic [sle_pkg::KindW-1:0] m_axis_tuser_o,  // [1:0] out_kind
  output logic                     m_axis_tlast_o,
  input  logic                     cfg_we_i,
  input  logic [sle_pkg::CountW-1:0] cfg_wdata_i    // line_limit
);

  `include "serial_line_editor_with_echo_defines.svh"

  localparam int AddrW = $clog2(LineDepth);
  localparam logic [sle_pkg::CountW-1:0] DepthC = sle_pkg::CountW'(LineDepth);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StEcho  = 5'b00010,
    StFetch = 5'b00100,
    StSend  = 5'b01000,
    StEnd   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [sle_pkg::CountW-1:0] limit_q;
  logic [sle_pkg::CountW-1:0] count_q, count_d;
  logic [sle_pkg::CountW-1:0] ptr_q, ptr_d;
  logic [sle_pkg::ByteW-1:0]  byte_q, byte_d;
  logic [1:0]                 idx_q, idx_d;

  logic                       out_valid_q;
  logic [sle_pkg::KindW-1:0]  out_kind_q, out_kind_d;
  logic [sle_pkg::ByteW-1:0]  out_byte_q, out_byte_d;
  logic [sle_pkg::CountW-1:0] out_len_q, out_len_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load;
  logic                       out_free;

  logic                       in_fire;
  logic                       is_print;
  logic                       ram_we;
  logic [sle_pkg::StoreW-1:0] ram_rdata;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign is_print = (s_axis_tdata_i >= sle_pkg::ByteSpace) &&
                    (s_axis_tdata_i <= sle_pkg::ByteTilde);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    byte_d     = byte_q;
    idx_d      = idx_q;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    out_kind_d = sle_pkg::KindEcho;
    out_byte_d = '0;
    out_len_d  = '0;
    out_last_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          byte_d = s_axis_tdata_i;
          idx_d  = 2'd0;
          if (s_axis_tdata_i == sle_pkg::ByteBs) begin
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
              state_d = StEcho;
            end
          end else if (is_print) begin
            if (count_q < limit_q && count_q < DepthC) begin
              ram_we  = 1'b1;
              count_d = count_q + 1'b1;
              state_d = StEcho;
            end
          end else if (s_axis_tdata_i == sle_pkg::ByteCr) begin
            ptr_d   = '0;
            state_d = (count_q == '0) ? StEnd : StFetch;
          end
        end
      end
      StEcho: begin
        if (out_free) begin
          out_load = 1'b1;
          if (byte_q == sle_pkg::ByteBs) begin
            // Backspace erases on the terminal with backspace, space, backspace.
            out_byte_d = (idx_q == 2'd1) ? sle_pkg::ByteSpace : sle_pkg::ByteBs;
            out_last_d = (idx_q == 2'd2);
            idx_d      = idx_q + 2'd1;
            if (idx_q == 2'd2) begin
              state_d = StIdle;
            end
          end else begin
            out_byte_d = byte_q;
            out_last_d = 1'b1;
            state_d    = StIdle;
          end
        end
      end
      StFetch: begin
        state_d = StSend;
      end
      StSend: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = sle_pkg::KindChar;
          out_byte_d = {1'b0, ram_rdata};
          ptr_d      = ptr_q + 1'b1;
          state_d    = (ptr_d == count_q) ? StEnd : StFetch;
        end
      end
      StEnd: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_d = sle_pkg::KindEnd;
          out_len_d  = count_q;
          out_last_d = 1'b1;
          count_d    = '0;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  sle_ram #(
    .Width(sle_pkg::StoreW),
    .Depth(LineDepth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(s_axis_tdata_i[sle_pkg::StoreW-1:0]),
    .raddr_i(ptr_q[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      limit_q     <= sle_pkg::LimitRst;
      count_q     <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_byte_q <= out_byte_d;
      out_len_q  <= out_len_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_len_q, out_byte_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  `SLE_ASSERT_SAME(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= DepthC,
    "line count exceeds the line memory depth")
  `SLE_ASSERT_SAME(a_walk_in_line, clk_i, rst_ni,
    state_q == StFetch || state_q == StSend, ptr_q < count_q,
    "line walk pointer beyond the stored characters")
  `SLE_ASSERT_NEXT(a_end_clears, clk_i, rst_ni,
    out_load && out_kind_d == sle_pkg::KindEnd, count_q == '0,
    "line end beat did not empty the line")
  `SLE_ASSERT_SAME(a_char_not_last, clk_i, rst_ni,
    out_valid_q && out_kind_q == sle_pkg::KindChar, !out_last_q,
    "line character beat marked as final")

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int Depth = LineDepthDef;
  localparam int NumPhases = 8;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] len;
    logic              tail;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_valid = 1'b0;
  logic [ByteW-1:0]  s_data = '0;
  logic              s_ready;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [DataW-1:0]  m_data;
  logic [KindW-1:0]  m_user;
  logic              m_last;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;

  // Bytes waiting to be sent and the result beats the line editor owes us.
  logic [ByteW-1:0]  rx_backlog[$];
  beat_t             beats_due[$];

  // Our own copy of the line being edited and of the limit register.
  logic [StoreW-1:0] line_chars[Depth];
  int unsigned       char_count = 0;
  logic [CountW-1:0] limit_cfg = LimitRst;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned edit_items = 0;
  int          fail_count = 0;

  logic [ByteW-1:0] opening_bytes[18] = '{
    ByteCr, ByteBs, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h1F, ByteSpace, ByteTilde,
    8'h41, ByteBs, 8'h62, 8'h0A, ByteCr, ByteBs, 8'h5A, 8'h09, ByteCr
  };
  int unsigned phase_limit[NumPhases]  = '{63, 1, 0, 5, 32, 0, 2, 20};
  int unsigned phase_sender[NumPhases] = '{0, 57, 0, 9, 57, 0, 9, 0};
  int unsigned phase_recv[NumPhases]   = '{0, 0, 57, 9, 0, 57, 9, 0};
  int unsigned phase_items[NumPhases]  = '{60, 45, 40, 50, 55, 55, 40, 45};

  serial_line_editor_with_echo u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void owe_beat(logic [KindW-1:0] kind, logic [ByteW-1:0] data,
                                   logic [CountW-1:0] len, logic tail);
    beat_t b;
    b.kind = kind;
    b.data = data;
    b.len  = len;
    b.tail = tail;
    beats_due.push_back(b);
  endfunction

  // Applies one received byte to the line and records the beats it must cause.
  function automatic void edit_line(logic [ByteW-1:0] c);
    int unsigned room;
    int unsigned i;
    room = (limit_cfg < Depth) ? limit_cfg : Depth;
    if (c == ByteBs) begin
      if (char_count > 0) begin
        char_count--;
        owe_beat(KindEcho, ByteBs, '0, 1'b0);
        owe_beat(KindEcho, ByteSpace, '0, 1'b0);
        owe_beat(KindEcho, ByteBs, '0, 1'b1);
      end
    end else if (c >= ByteSpace && c <= ByteTilde) begin
      if (char_count < room) begin
        line_chars[char_count] = c[StoreW-1:0];
        char_count++;
        owe_beat(KindEcho, c, '0, 1'b1);
      end
    end else if (c == ByteCr) begin
      for (i = 0; i < char_count; i++) begin
        owe_beat(KindChar, {1'b0, line_chars[i]}, '0, 1'b0);
      end
      owe_beat(KindEnd, '0, char_count[CountW-1:0], 1'b1);
      char_count = 0;
    end
  endfunction

  // Driver: a new byte is offered once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) begin
        edit_line(s_data);
      end
      if (!s_valid || s_ready) begin
        if (rx_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_valid <= 1'b1;
          s_data  <= rx_backlog.pop_front();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    beat_t want;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        if (beats_due.size() == 0) begin
          $error("beat with nothing due: out_kind %0d out_byte %0h", m_user, m_data[7:0]);
          fail_count++;
        end else begin
          want = beats_due.pop_front();
          if (m_user !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, m_user);
            fail_count++;
          end
          if (m_data[7:0] !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, m_data[7:0]);
            fail_count++;
          end
          if (m_data[13:8] !== want.len) begin
            $error("line_length: expected %0d, actual %0d", want.len, m_data[13:8]);
            fail_count++;
          end
          if (m_last !== want.tail) begin
            $error("last: expected %0d, actual %0d", want.tail, m_last);
            fail_count++;
          end
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_rx(logic [ByteW-1:0] b);
    rx_backlog.push_back(b);
    edit_items++;
  endtask

  // Mostly complete lines with random text and the odd backspace; some random
  // noise and some lines left open so that the next one runs on into them.
  task automatic queue_lines(int unsigned budget, int unsigned lim);
    int unsigned span;
    int unsigned len;
    int unsigned r;
    int unsigned j;
    span = ((lim < Depth) ? lim : Depth) + 2;
    edit_items = 0;
    while (edit_items < budget) begin
      r = $urandom_range(99);
      if (r < 12) begin
        repeat ($urandom_range(1, 4)) push_rx(ByteW'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(0, span);
        for (j = 0; j < len && edit_items < budget; j++) begin
          if ($urandom_range(7) == 0) begin
            push_rx(ByteBs);
          end else begin
            push_rx(ByteW'($urandom_range(ByteSpace, ByteTilde)));
          end
        end
        if (r >= 20 && edit_items < budget) begin
          push_rx(ByteCr);
        end
      end
    end
  endtask

  // Waits until every byte is taken and every beat has arrived, then gives
  // dropped bytes time to drain out of the block.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (rx_backlog.size() != 0 || s_valid || beats_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [CountW-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_cfg = v;
  endtask

  initial begin
    int unsigned p;
    int unsigned lim;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_bytes[k]) push_rx(opening_bytes[k]);
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      lim = (p == 5) ? $urandom_range(1, 63) : phase_limit[p];
      write_limit(lim[CountW-1:0]);
      sender_idle_pct = phase_sender[p];
      recv_stall_pct  = phase_recv[p];
      queue_lines(phase_items[p], lim);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_ram.sv
hdl/serial_line_editor_with_echo.sv
sim/testbench.sv
